@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion helpers for the point rotation core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define PROT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PROT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/prot_pkg.sv @@
// ---------------------------------------------------------------------------
// prot_pkg
// Types, constants and helper functions shared by the point rotation core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prot_pkg;

    // Field formats.
    localparam int CW    = 32;      // coordinate width, Q16.16
    localparam int AW    = 16;      // angle width, Q3.13
    localparam int AFRAC = AW - 3;

    // Pipeline geometry.
    localparam int TERMS     = 10;  // series terms after the leading one
    localparam int ROOT_BITS = 31;  // bits of the axis norm
    localparam int QUOT_BITS = 31;  // bits of each unit axis component
    localparam int AXIS_LAT  = 5 + ROOT_BITS + 1 + QUOT_BITS + 1;
    localparam int TRIG_LAT  = 1 + 4 * TERMS + 1;
    localparam int ANG_DLY   = AXIS_LAT - TRIG_LAT;
    localparam int SIDE_DLY  = AXIS_LAT + 3;
    localparam int PIPE_DEPTH = 1 + AXIS_LAT + 6;

    // Q30 constants.
    localparam logic [32:0] ONE_Q30     = 33'h0_4000_0000;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [33:0] PI_Q30      = 34'd3373259426;

    // Series denominators: lane 0 is sine, lane 1 is cosine.
    localparam logic [8:0] TERM_DIV [2][TERMS] = '{
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420},
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380}
    };

    // Reciprocals scaled by 2^36, rounded down.
    localparam logic [35:0] TERM_RECIP [2][TERMS] = '{
        '{36'((64'd1 << 36) / 64'd6),   36'((64'd1 << 36) / 64'd20),
          36'((64'd1 << 36) / 64'd42),  36'((64'd1 << 36) / 64'd72),
          36'((64'd1 << 36) / 64'd110), 36'((64'd1 << 36) / 64'd156),
          36'((64'd1 << 36) / 64'd210), 36'((64'd1 << 36) / 64'd272),
          36'((64'd1 << 36) / 64'd342), 36'((64'd1 << 36) / 64'd420)},
        '{36'((64'd1 << 36) / 64'd2),   36'((64'd1 << 36) / 64'd12),
          36'((64'd1 << 36) / 64'd30),  36'((64'd1 << 36) / 64'd56),
          36'((64'd1 << 36) / 64'd90),  36'((64'd1 << 36) / 64'd132),
          36'((64'd1 << 36) / 64'd182), 36'((64'd1 << 36) / 64'd240),
          36'((64'd1 << 36) / 64'd306), 36'((64'd1 << 36) / 64'd380)}
    };

    // Which of the six distinct axis products feeds matrix entry (row, col).
    localparam logic [2:0] UU_IDX [3][3] = '{
        '{3'd0, 3'd3, 3'd4},
        '{3'd3, 3'd1, 3'd5},
        '{3'd4, 3'd5, 3'd2}
    };

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord                axis_start_x;
        t_coord                axis_start_y;
        t_coord                axis_start_z;
        t_coord                axis_end_x;
        t_coord                axis_end_y;
        t_coord                axis_end_z;
        t_coord                point_x;
        t_coord                point_y;
        t_coord                point_z;
        logic signed [AW-1:0]  turn_angle;
    } t_in_item;

    typedef struct packed {
        t_coord rotated_x;
        t_coord rotated_y;
        t_coord rotated_z;
        logic   axis_degenerate;
    } t_out_item;

    // Per-item data that rides alongside the axis and angle pipelines.
    typedef struct packed {
        logic [2:0][CW-1:0] b;
        logic [2:0][CW-1:0] d;
        logic [2:0][2:0]    hi;
        logic [2:0][29:0]   lo;
        logic               deg;
    } t_side;

    // Q30 product on sign and magnitude, rounded half up on the magnitude.
    function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] pr;
        logic [33:0] r;
        ma = a[32] ? 32'(-a) : 32'(a);
        mb = b[32] ? 32'(-b) : 32'(b);
        pr = 64'(ma) * 64'(mb);
        r  = 34'((pr + 64'h2000_0000) >> 30);
        return (a[32] ^ b[32]) ? 33'(-$signed({1'b0, r})) : 33'($signed({1'b0, r}));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/prot_stream_if.sv @@
// ---------------------------------------------------------------------------
// prot_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prot_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/point_rotation_about_axis_top.sv @@
// ---------------------------------------------------------------------------
// point_rotation_about_axis_top
// Rotates a point about the line through two axis points by a given angle.
// ---------------------------------------------------------------------------
// Usage:
//   i_pt carries one item per beat: axis points B and C, point D (signed
//   Q16.16) and the angle (signed Q3.13 radians). o_res returns the rotated
//   point, saturated to Q16.16, and a flag set when B equals C, in which
//   case D comes back unchanged.
//   Every accepted beat gives exactly one result beat, in order.
//   Throughput is one item per cycle while o_res is not stalled. The
//   latency is set by the axis path: a 31-stage square root and a 31-stage
//   divider, one bit per stage; the sine and cosine series (42 stages) run
//   beside it.
//   The pipeline advances as a whole whenever the output register is empty
//   or being taken, so i_pt.ready is low only while a result waits on a
//   stalled o_res; a stall holds every stage and loses nothing.
//   Synchronous reset (i_rst_n low) clears all valid bits; no result is
//   presented until new items arrive.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module point_rotation_about_axis_top
    import prot_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    prot_stream_if.sink   i_pt,
    prot_stream_if.source o_res
);

    localparam logic signed [34:0] E_POS = 35'sh0_4000_0000;
    localparam logic signed [34:0] E_NEG = -35'sh0_4000_0000;
    localparam logic signed [38:0] C_MAX = 39'sh0_7FFF_FFFF;
    localparam logic signed [38:0] C_MIN = -39'sh0_8000_0000;

    // Pipeline control: one enable for all stages.
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  en;

    assign en          = !r_vld[PIPE_DEPTH-1] || o_res.ready;
    assign i_pt.ready  = en;
    assign o_res.valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pt.valid};
        end
    end

    // Stage 1: axis vector, offset of D from B, degenerate check.
    logic [2:0][CW-1:0] in_b;
    logic [2:0][CW-1:0] in_c;
    logic [2:0][CW-1:0] in_d;
    logic [2:0][32:0]   w;
    logic [2:0][32:0]   p;
    logic [2:0][32:0]   n_mag;
    logic [2:0]         n_neg;
    t_side              n_side;

    assign in_b = {i_pt.payload.axis_start_z, i_pt.payload.axis_start_y,
                   i_pt.payload.axis_start_x};
    assign in_c = {i_pt.payload.axis_end_z, i_pt.payload.axis_end_y,
                   i_pt.payload.axis_end_x};
    assign in_d = {i_pt.payload.point_z, i_pt.payload.point_y, i_pt.payload.point_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i]         = {in_c[i][CW-1], in_c[i]} - {in_b[i][CW-1], in_b[i]};
            p[i]         = {in_d[i][CW-1], in_d[i]} - {in_b[i][CW-1], in_b[i]};
            n_mag[i]     = w[i][32] ? 33'(-w[i]) : w[i];
            n_neg[i]     = w[i][32];
            n_side.hi[i] = p[i][32:30];
            n_side.lo[i] = p[i][29:0];
        end
        n_side.b   = in_b;
        n_side.d   = in_d;
        n_side.deg = (in_b == in_c);
    end

    logic [2:0][32:0]     r1_mag;
    logic [2:0]           r1_neg;
    t_side                r1_side;
    logic signed [AW-1:0] r1_ang;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag  <= n_mag;
            r1_neg  <= n_neg;
            r1_side <= n_side;
            r1_ang  <= i_pt.payload.turn_angle;
        end
    end

    // Unit axis, ready at stage 70.
    logic [2:0][31:0] u;

    prot_axis u_axis (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r1_mag),
        .i_neg (r1_neg),
        .o_u   (u)
    );

    // Angle delayed so that sine and cosine also land at stage 70.
    logic signed [AW-1:0] r_ang [ANG_DLY];
    logic signed [31:0]   sn;
    logic signed [31:0]   cs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= r1_ang;
            for (int i = 1; i < ANG_DLY; i++) begin
                r_ang[i] <= r_ang[i-1];
            end
        end
    end

    prot_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_ang[ANG_DLY-1]),
        .o_sin   (sn),
        .o_cos   (cs)
    );

    // Side data follows the item up to the matrix stage.
    t_side r_side [SIDE_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r1_side;
            for (int i = 1; i < SIDE_DLY; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Stage 71: axis outer products, sine cross terms, one minus cosine.
    logic signed [32:0] r71_uu [6];
    logic signed [32:0] r71_su [3];
    logic signed [32:0] r71_omc;
    logic signed [31:0] r71_cs;
    logic signed [32:0] ue [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ue[i] = $signed({u[i][31], u[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r71_uu[0] <= mulq(ue[0], ue[0]);
            r71_uu[1] <= mulq(ue[1], ue[1]);
            r71_uu[2] <= mulq(ue[2], ue[2]);
            r71_uu[3] <= mulq(ue[0], ue[1]);
            r71_uu[4] <= mulq(ue[0], ue[2]);
            r71_uu[5] <= mulq(ue[1], ue[2]);
            for (int i = 0; i < 3; i++) begin
                r71_su[i] <= mulq({sn[31], sn}, ue[i]);
            end
            r71_omc <= $signed(ONE_Q30) - $signed({cs[31], cs});
            r71_cs  <= cs;
        end
    end

    // Stage 72: scale the outer products by one minus cosine.
    logic signed [32:0] r72_m [3][3];
    logic signed [32:0] r72_su [3];
    logic signed [31:0] r72_cs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r72_m[i][j] <= mulq(r71_uu[UU_IDX[i][j]], r71_omc);
                end
            end
            r72_su <= r71_su;
            r72_cs <= r71_cs;
        end
    end

    // Stage 73: add the cosine diagonal and the skew sine terms, then clamp.
    logic signed [34:0] adj [3][3];
    logic signed [34:0] esum [3][3];
    logic signed [31:0] r73_e [3][3];
    logic signed [34:0] cs35;
    logic signed [34:0] su35 [3];

    always_comb begin
        cs35 = 35'(r72_cs);
        for (int i = 0; i < 3; i++) begin
            su35[i] = 35'(r72_su[i]);
        end
        adj[0][0] = cs35;
        adj[1][1] = cs35;
        adj[2][2] = cs35;
        adj[0][1] = -su35[2];
        adj[0][2] = su35[1];
        adj[1][0] = su35[2];
        adj[1][2] = -su35[0];
        adj[2][0] = -su35[1];
        adj[2][1] = su35[0];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                esum[i][j] = 35'(r72_m[i][j]) + adj[i][j];
                if (esum[i][j] > E_POS) begin
                    esum[i][j] = E_POS;
                end else if (esum[i][j] < E_NEG) begin
                    esum[i][j] = E_NEG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r73_e[i][j] <= 32'(esum[i][j]);
                end
            end
        end
    end

    // Stage 74: matrix times the offset, split into high and low parts.
    logic signed [62:0] r74_plo [3][3];
    logic signed [34:0] r74_phi [3][3];
    t_side              r74_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r74_plo[i][j] <= 63'(r73_e[i][j]) *
                                     $signed({33'd0, r_side[SIDE_DLY-1].lo[j]});
                    r74_phi[i][j] <= 35'(r73_e[i][j]) *
                                     35'($signed(r_side[SIDE_DLY-1].hi[j]));
                end
            end
            r74_side <= r_side[SIDE_DLY-1];
        end
    end

    // Stage 75: row sums, low part rounded back to Q16.16 units.
    logic signed [64:0] acc_lo [3];
    logic signed [36:0] acc_hi [3];
    logic signed [37:0] r75_pre [3];
    t_side              r75_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_lo[i] = 65'(r74_plo[i][0]) + 65'(r74_plo[i][1]) + 65'(r74_plo[i][2])
                        + 65'sh2000_0000;
            acc_hi[i] = 37'(r74_phi[i][0]) + 37'(r74_phi[i][1]) + 37'(r74_phi[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r75_pre[i] <= 38'(acc_hi[i]) + 38'(acc_lo[i] >>> 30);
            end
            r75_side <= r74_side;
        end
    end

    // Stage 76: add B back, saturate, or pass D for a degenerate axis.
    logic signed [38:0] res [3];
    logic [2:0][CW-1:0] n_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i] = 39'(r75_pre[i]) + 39'($signed(r75_side.b[i]));
            if (r75_side.deg) begin
                n_out[i] = r75_side.d[i];
            end else if (res[i] > C_MAX) begin
                n_out[i] = CW'(C_MAX);
            end else if (res[i] < C_MIN) begin
                n_out[i] = CW'(C_MIN);
            end else begin
                n_out[i] = CW'(res[i]);
            end
        end
    end

    t_out_item r76_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r76_out.rotated_x       <= n_out[0];
            r76_out.rotated_y       <= n_out[1];
            r76_out.rotated_z       <= n_out[2];
            r76_out.axis_degenerate <= r75_side.deg;
        end
    end

    assign o_res.payload = r76_out;

    // Checks on the pipeline control.
    `PROT_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_res.valid, "valid after reset")
    `PROT_ASSERT(a_stall_freezes, (o_res.valid && !o_res.ready) |=> $stable(r_vld), "stall moved pipe")
    `PROT_ASSERT(a_accept_enters, (i_pt.valid && i_pt.ready) |=> r_vld[0], "accepted beat lost")

endmodule

`default_nettype wire

@@ rtl/core/prot_sincos.sv @@
// ---------------------------------------------------------------------------
// prot_sincos
// Pipelined sine and cosine in Q30 from a Q3.13 angle by Taylor series.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prot_sincos
    import prot_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [AW-1:0] i_angle,
    output logic signed [31:0]  o_sin,
    output logic signed [31:0]  o_cos
);

    localparam int NST = 4 * TERMS;
    localparam logic signed [33:0] POS_ONE = 34'sh0_4000_0000;
    localparam logic signed [33:0] NEG_ONE = -34'sh0_4000_0000;

    typedef struct packed {
        logic [30:0] t;
        logic        sneg;
        logic        cneg;
    } t_trig_ctl;

    t_trig_ctl         r_ctl [NST+1];
    logic [31:0]       r_w   [NST+1][2];
    logic signed [33:0] r_sum [NST+1][2];
    logic [31:0]       r_x   [TERMS][2];

    // Angle magnitude folded into [0, pi/2].
    logic [32:0]        ang;
    logic [32:0]        t0;
    logic signed [33:0] rdiff;
    logic [33:0]        rmag;
    t_trig_ctl          n_ctl;

    always_comb begin
        ang   = {{(33 - AW){i_angle[AW-1]}}, i_angle} << (30 - AFRAC);
        t0    = ang[32] ? 33'(-ang) : ang;
        rdiff = $signed(PI_Q30 - {1'b0, t0});
        rmag  = rdiff[33] ? 34'(-rdiff) : 34'(rdiff);
        n_ctl.sneg = ang[32];
        n_ctl.cneg = 1'b0;
        n_ctl.t    = 31'(t0);
        if (t0 > HALF_PI_Q30) begin
            n_ctl.cneg = 1'b1;
            n_ctl.sneg = ang[32] ^ rdiff[33];
            n_ctl.t    = 31'(rmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0]    <= n_ctl;
            r_w[0][0]   <= {1'b0, n_ctl.t};
            r_w[0][1]   <= 32'(ONE_Q30);
            r_sum[0][0] <= $signed(34'(n_ctl.t));
            r_sum[0][1] <= $signed(34'(ONE_Q30));
        end
    end

    // Each term takes four stages: two Q30 products, a reciprocal product and
    // a one-step quotient correction.
    for (genvar k = 0; k < TERMS; k++) begin : g_term
        localparam int B = 4 * k;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [31:0] d_rem;
            logic [31:0] d_q;

            assign d_rem = r_x[k][l] - 32'(r_w[B+3][l] * 32'(TERM_DIV[l][k]));
            assign d_q   = r_w[B+3][l] + 32'(d_rem >= 32'(TERM_DIV[l][k]));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_w[B+1][l]   <= 32'((64'(r_w[B][l]) * 64'(r_ctl[B].t)) >> 30);
                    r_sum[B+1][l] <= r_sum[B][l];
                    r_w[B+2][l]   <= 32'((64'(r_w[B+1][l]) * 64'(r_ctl[B+1].t)) >> 30);
                    r_sum[B+2][l] <= r_sum[B+1][l];
                    r_w[B+3][l]   <= 32'((68'(r_w[B+2][l]) * 68'(TERM_RECIP[l][k])) >> 36);
                    r_x[k][l]     <= r_w[B+2][l];
                    r_sum[B+3][l] <= r_sum[B+2][l];
                    r_w[B+4][l]   <= d_q;
                    if ((k % 2) == 0) begin
                        r_sum[B+4][l] <= r_sum[B+3][l] - $signed(34'(d_q));
                    end else begin
                        r_sum[B+4][l] <= r_sum[B+3][l] + $signed(34'(d_q));
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[B+1] <= r_ctl[B];
                r_ctl[B+2] <= r_ctl[B+1];
                r_ctl[B+3] <= r_ctl[B+2];
                r_ctl[B+4] <= r_ctl[B+3];
            end
        end
    end

    // Clamp to the unit range and restore the signs.
    logic signed [33:0] cl_s;
    logic signed [33:0] cl_c;

    always_comb begin
        cl_s = r_sum[NST][0];
        if (cl_s > POS_ONE) begin
            cl_s = POS_ONE;
        end else if (cl_s < NEG_ONE) begin
            cl_s = NEG_ONE;
        end
        cl_c = r_sum[NST][1];
        if (cl_c > POS_ONE) begin
            cl_c = POS_ONE;
        end else if (cl_c < NEG_ONE) begin
            cl_c = NEG_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= 32'(r_ctl[NST].sneg ? -cl_s : cl_s);
            o_cos <= 32'(r_ctl[NST].cneg ? -cl_c : cl_c);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/prot_axis.sv @@
// ---------------------------------------------------------------------------
// prot_axis
// Pipelined unit axis: normalize, integer square root, rounded division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prot_axis
    import prot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2:0][32:0]  i_mag,
    input  logic [2:0]        i_neg,
    output logic [2:0][31:0]  o_u
);

    // Largest magnitude.
    logic [2:0][32:0] r2_mag;
    logic [2:0]       r2_neg;
    logic [32:0]      r2_mx;
    logic [32:0]      mx01;

    assign mx01 = (i_mag[1] > i_mag[0]) ? i_mag[1] : i_mag[0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag <= i_mag;
            r2_neg <= i_neg;
            r2_mx  <= (i_mag[2] > mx01) ? i_mag[2] : mx01;
        end
    end

    // Leading one of the largest magnitude sets the normalizing shift.
    logic [5:0]       lead;
    logic [2:0][32:0] r3_mag;
    logic [2:0]       r3_neg;
    logic [1:0]       r3_rsh;
    logic [4:0]       r3_lsh;

    always_comb begin
        lead = '0;
        for (int i = 0; i < 33; i++) begin
            if (r2_mx[i]) begin
                lead = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_rsh <= (lead > 6'd29) ? 2'(lead - 6'd29) : 2'd0;
            r3_lsh <= (lead < 6'd29) ? 5'(6'd29 - lead) : 5'd0;
        end
    end

    // Shift so that the largest magnitude lies in [2^29, 2^30).
    logic [2:0][29:0] r4_nm;
    logic [2:0]       r4_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_nm[i] <= 30'((r3_mag[i] >> r3_rsh) << r3_lsh);
            end
            r4_neg <= r3_neg;
        end
    end

    // Squares, then their sum.
    logic [2:0][59:0] r5_sq;
    logic [2:0][29:0] r5_nm;
    logic [2:0]       r5_neg;
    logic [61:0]      r6_n2;
    logic [2:0][29:0] r6_nm;
    logic [2:0]       r6_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= 60'(r4_nm[i]) * 60'(r4_nm[i]);
            end
            r5_nm  <= r4_nm;
            r5_neg <= r4_neg;
            r6_n2  <= 62'(r5_sq[0]) + 62'(r5_sq[1]) + 62'(r5_sq[2]);
            r6_nm  <= r5_nm;
            r6_neg <= r5_neg;
        end
    end

    // Integer square root, one root bit per stage, most significant first.
    logic [30:0]      r_root [ROOT_BITS];
    logic [61:0]      r_rem  [ROOT_BITS];
    logic [2:0][29:0] r_rnm  [ROOT_BITS];
    logic [2:0]       r_rneg [ROOT_BITS];

    for (genvar s = 0; s < ROOT_BITS; s++) begin : g_root
        localparam int K = ROOT_BITS - 1 - s;
        logic [30:0]      root_in;
        logic [61:0]      rem_in;
        logic [2:0][29:0] nm_in;
        logic [2:0]       neg_in;
        logic [63:0]      trial;

        if (s == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = r6_n2;
            assign nm_in   = r6_nm;
            assign neg_in  = r6_neg;
        end else begin : g_next
            assign root_in = r_root[s-1];
            assign rem_in  = r_rem[s-1];
            assign nm_in   = r_rnm[s-1];
            assign neg_in  = r_rneg[s-1];
        end

        assign trial = (64'(root_in) << (K + 1)) + (64'd1 << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (64'(rem_in) >= trial) begin
                    r_rem[s]  <= 62'(64'(rem_in) - trial);
                    r_root[s] <= root_in | (31'd1 << K);
                end else begin
                    r_rem[s]  <= rem_in;
                    r_root[s] <= root_in;
                end
                r_rnm[s]  <= nm_in;
                r_rneg[s] <= neg_in;
            end
        end
    end

    // Numerators with half the norm added for rounding.
    logic [2:0][60:0] r_num;
    logic [30:0]      r_nrm;
    logic [2:0]       r_nneg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {1'b0, r_rnm[ROOT_BITS-1][i], 30'b0}
                            + 61'(r_root[ROOT_BITS-1] >> 1);
            end
            r_nrm  <= r_root[ROOT_BITS-1];
            r_nneg <= r_rneg[ROOT_BITS-1];
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes.
    logic [2:0][60:0] r_drem [QUOT_BITS];
    logic [2:0][30:0] r_quo  [QUOT_BITS];
    logic [30:0]      r_dnrm [QUOT_BITS];
    logic [2:0]       r_dneg [QUOT_BITS];

    for (genvar s = 0; s < QUOT_BITS; s++) begin : g_div
        localparam int K = QUOT_BITS - 1 - s;
        logic [2:0][60:0] rem_in;
        logic [2:0][30:0] quo_in;
        logic [30:0]      nrm_in;
        logic [2:0]       neg_in;
        logic [61:0]      den;

        if (s == 0) begin : g_first
            assign rem_in = r_num;
            assign quo_in = '0;
            assign nrm_in = r_nrm;
            assign neg_in = r_nneg;
        end else begin : g_next
            assign rem_in = r_drem[s-1];
            assign quo_in = r_quo[s-1];
            assign nrm_in = r_dnrm[s-1];
            assign neg_in = r_dneg[s-1];
        end

        assign den = 62'(nrm_in) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (62'(rem_in[i]) >= den) begin
                        r_drem[s][i] <= 61'(62'(rem_in[i]) - den);
                        r_quo[s][i]  <= quo_in[i] | (31'd1 << K);
                    end else begin
                        r_drem[s][i] <= rem_in[i];
                        r_quo[s][i]  <= quo_in[i];
                    end
                end
                r_dnrm[s] <= nrm_in;
                r_dneg[s] <= neg_in;
            end
        end
    end

    // Apply the axis signs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_u[i] <= r_dneg[QUOT_BITS-1][i] ? 32'(-{1'b0, r_quo[QUOT_BITS-1][i]})
                                                 : {1'b0, r_quo[QUOT_BITS-1][i]};
            end
        end
    end

endmodule

`default_nettype wire
